@@ src/hrv_time_domain_metrics_top_defines.svh @@
// Assertion macros shared by the HRV time-domain block.
// HRV_ASSERT checks an expression at every clock edge out of reset.
// HRV_ASSERT_NEXT checks that the consequent holds in the cycle after the antecedent.
`ifndef HRV_TIME_DOMAIN_METRICS_TOP_DEFINES_SVH
`define HRV_TIME_DOMAIN_METRICS_TOP_DEFINES_SVH
`ifndef SYNTH
`define HRV_ASSERT(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);
`define HRV_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define HRV_ASSERT(lbl, expr, msg)
`define HRV_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

@@ src/hrv_tdm_pkg.sv @@
package hrv_tdm_pkg;

	localparam int unsigned VAL_W             = 22;
	localparam int unsigned MAX_INTERVALS_DEF = 65536;
	// count width for the largest supported record length
	localparam int unsigned REC_CNT_W         = 21;
	localparam int unsigned IDX_W             = 4;
	localparam int unsigned MET_W             = 32;
	localparam int unsigned NUM_METRICS       = 14;
	localparam int unsigned Q_DEPTH           = 4;
	localparam int unsigned Q_PTR_W           = 2;
	localparam logic [VAL_W-1:0] THR_RESET    = 22'd50000;

	typedef enum logic [IDX_W-1:0] {
		MET_TOTAL    = 4'd0,
		MET_ACCEPTED = 4'd1,
		MET_EXCLUDED = 4'd2,
		MET_CLIPPED  = 4'd3,
		MET_ECTOPIC  = 4'd4,
		MET_ARTIFACT = 4'd5,
		MET_MEAN     = 4'd6,
		MET_HR       = 4'd7,
		MET_SDNN     = 4'd8,
		MET_RMSSD    = 4'd9,
		MET_PNN50    = 4'd10,
		MET_SD1      = 4'd11,
		MET_SD2      = 4'd12,
		MET_RATIO    = 4'd13
	} metric_e;

	// queued interval; keep is low once the record has reached its length limit
	typedef struct packed {
		logic [VAL_W-1:0] rr_value_us;
		logic             is_clipped;
		logic             is_ectopic;
		logic             has_artifact;
		logic             is_excluded;
		logic             last_interval;
		logic             keep;
	} item_t;

	// record totals handed from the accumulator to the metric engine
	typedef struct packed {
		logic [REC_CNT_W-1:0] total;
		logic [REC_CNT_W-1:0] accepted;
		logic [REC_CNT_W-1:0] excluded;
		logic [REC_CNT_W-1:0] clipped;
		logic [REC_CNT_W-1:0] ectopic;
		logic [REC_CNT_W-1:0] artifact;
		logic [REC_CNT_W-1:0] pairs;
		logic [REC_CNT_W-1:0] over;
		logic [63:0]          s1;
		logic [63:0]          s2;
		logic [63:0]          d1;   // two's complement
		logic [63:0]          d2;
	} rec_t;

endpackage

@@ src/hrv_tdm_ifs.sv @@
interface hrv_tdm_in_if import hrv_tdm_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [VAL_W-1:0] rr_value_us;
	logic             is_clipped;
	logic             is_ectopic;
	logic             has_artifact;
	logic             is_excluded;
	logic             last_interval;

	modport source (output valid, rr_value_us, is_clipped, is_ectopic, has_artifact,
		is_excluded, last_interval, input ready);
	modport sink (input valid, rr_value_us, is_clipped, is_ectopic, has_artifact,
		is_excluded, last_interval, output ready);
endinterface

interface hrv_tdm_out_if import hrv_tdm_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [IDX_W-1:0] metric_index;
	logic [MET_W-1:0] metric_value;
	logic             last_metric;

	modport source (output valid, metric_index, metric_value, last_metric, input ready);
	modport sink (input valid, metric_index, metric_value, last_metric, output ready);
endinterface

@@ src/hrv_time_domain_metrics_top.sv @@
// HRV time-domain metrics. Each input word is one RR interval (microseconds)
// with its quality flags; a word with last_interval set closes the record and
// the block then returns 14 metric words, index 0 through 13 in order, the last
// one flagged with last_metric. Intervals stream in at one per cycle while the
// accumulator is taking them: a 4-deep queue sits in front of a two-stage
// square-and-accumulate pipeline, so input ready only drops when that queue
// fills. Once the last interval reaches the accumulator and the pipeline has
// drained, the record totals pass to the metric engine, and the accumulator
// clears and takes the next record right away, as long as the engine is free.
// The engine works through one shared iterative unit: a shift-add multiply, a
// restoring divide and a square root, each of which loads its operands, iterates
// and finishes. A full run is 8 multiplies, 7 divides and 4 roots, then 14
// output words at up to one per cycle; records with no accepted intervals or no
// valid pairs skip the unused steps. A second record closing before the engine
// is done waits in the accumulator, and input backs up into the queue. Intervals
// past MAX_INTERVALS in one record are dropped, though their last marker still
// ends the record. The pNN50 threshold (cfg_wdata, written with cfg_we) resets
// to 50000 us and must only be changed while the block is idle. All outputs
// saturate at 2^32-1.

module hrv_time_domain_metrics_top import hrv_tdm_pkg::*; #(
	parameter int unsigned MAX_INTERVALS = MAX_INTERVALS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [VAL_W-1:0] cfg_wdata,
	hrv_tdm_in_if.sink       rr_in,
	hrv_tdm_out_if.source    metric_out
);

	item_t head;
	logic  head_valid;
	logic  pop;
	rec_t  rec;
	logic  rec_valid;
	logic  rec_ready;

	// front: accept, tag intervals past the record limit, queue
	hrv_tdm_front #(
		.MAX_INTERVALS(MAX_INTERVALS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.rr_in     (rr_in),
		.head      (head),
		.head_valid(head_valid),
		.pop       (pop)
	);

	// back, part one: per-interval counts and sums, one interval per cycle while running
	hrv_tdm_acc #(
		.MAX_INTERVALS(MAX_INTERVALS)
	) u_acc (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.head      (head),
		.head_valid(head_valid),
		.pop       (pop),
		.rec       (rec),
		.rec_valid (rec_valid),
		.rec_ready (rec_ready)
	);

	// back, part two: end-of-record multiplies, divides and roots, metric word output
	hrv_tdm_calc u_calc (
		.clk       (clk),
		.arst_n    (arst_n),
		.rec       (rec),
		.rec_valid (rec_valid),
		.rec_ready (rec_ready),
		.metric_out(metric_out)
	);

endmodule

@@ src/hrv_tdm_front.sv @@
`include "hrv_time_domain_metrics_top_defines.svh"

module hrv_tdm_front import hrv_tdm_pkg::*; #(
	parameter int unsigned MAX_INTERVALS = MAX_INTERVALS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	hrv_tdm_in_if.sink   rr_in,
	output item_t        head,
	output logic         head_valid,
	input  logic         pop
);

	localparam int unsigned CNT_W = $clog2(MAX_INTERVALS + 1);

	item_t              mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_q;
	logic [Q_PTR_W-1:0] rd_q;
	logic [Q_PTR_W:0]   cnt_q;
	logic [CNT_W-1:0]   rec_cnt_q;
	logic               push;
	logic               keep;
	item_t              item;

	assign rr_in.ready = (cnt_q != (Q_PTR_W+1)'(Q_DEPTH));
	assign push        = rr_in.valid && rr_in.ready;
	assign keep        = (rec_cnt_q < CNT_W'(MAX_INTERVALS));

	always_comb begin
		item.rr_value_us   = rr_in.rr_value_us;
		item.is_clipped    = rr_in.is_clipped;
		item.is_ectopic    = rr_in.is_ectopic;
		item.has_artifact  = rr_in.has_artifact;
		item.is_excluded   = rr_in.is_excluded;
		item.last_interval = rr_in.last_interval;
		item.keep          = keep;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q      <= '0;
			rd_q      <= '0;
			cnt_q     <= '0;
			rec_cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
				if (rr_in.last_interval) begin
					rec_cnt_q <= '0;
				end else if (keep) begin
					rec_cnt_q <= rec_cnt_q + 1'b1;
				end
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	assign head       = mem_q[rd_q];
	assign head_valid = (cnt_q != '0);

	`HRV_ASSERT(a_q_bound, cnt_q <= (Q_PTR_W+1)'(Q_DEPTH), "queue fill above depth")

endmodule

@@ src/hrv_tdm_acc.sv @@
`include "hrv_time_domain_metrics_top_defines.svh"

module hrv_tdm_acc import hrv_tdm_pkg::*; #(
	parameter int unsigned MAX_INTERVALS = MAX_INTERVALS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [VAL_W-1:0] cfg_wdata,
	input  item_t            head,
	input  logic             head_valid,
	output logic             pop,
	output rec_t             rec,
	output logic             rec_valid,
	input  logic             rec_ready
);

	localparam int unsigned CNT_W = $clog2(MAX_INTERVALS + 1);
	localparam int unsigned S1_W  = CNT_W + VAL_W;
	localparam int unsigned DF_W  = VAL_W + 1;
	localparam int unsigned D1_W  = CNT_W + VAL_W + 1;

	typedef enum logic [1:0] {A_RUN, A_DRAIN, A_HAND} acc_state_t;

	acc_state_t       st_q;
	logic [VAL_W-1:0] thr_q;
	logic [CNT_W-1:0] total_q, accepted_q, excluded_q, clipped_q;
	logic [CNT_W-1:0] ectopic_q, artifact_q, pairs_q, over_q;
	logic [S1_W-1:0]  s1_q;
	logic [63:0]      s2_q;
	logic [D1_W-1:0]  d1_q;
	logic [63:0]      d2_q;
	logic [VAL_W-1:0] prev_q;
	logic             prev_excl_q;

	// stage 1: value, difference; stage 2: squares
	logic              acc_s1, pair_s1, acc_s2, pair_s2;
	logic [VAL_W-1:0]  v_s1, mag_s1, v_s2;
	logic [DF_W-1:0]   diff_s1, diff_s2;
	logic [2*VAL_W-1:0] vsq_s2, msq_s2;

	logic             take;
	logic             is_pair;
	logic [VAL_W-1:0] mag;
	logic [DF_W-1:0]  diff;
	logic [64:0]      s2_sum, d2_sum;

	assign pop     = head_valid && (st_q == A_RUN);
	assign take    = pop && head.keep;
	assign is_pair = !head.is_excluded && !prev_excl_q;
	assign mag     = (head.rr_value_us >= prev_q) ? head.rr_value_us - prev_q
	                                              : prev_q - head.rr_value_us;
	assign diff    = {1'b0, head.rr_value_us} - {1'b0, prev_q};
	assign s2_sum  = {1'b0, s2_q} + 65'(vsq_s2);
	assign d2_sum  = {1'b0, d2_q} + 65'(msq_s2);

	always_ff @(posedge clk) begin
		v_s1    <= head.rr_value_us;
		mag_s1  <= mag;
		diff_s1 <= diff;
		v_s2    <= v_s1;
		diff_s2 <= diff_s1;
		vsq_s2  <= v_s1 * v_s1;
		msq_s2  <= mag_s1 * mag_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= A_RUN;
			thr_q       <= THR_RESET;
			total_q     <= '0;
			accepted_q  <= '0;
			excluded_q  <= '0;
			clipped_q   <= '0;
			ectopic_q   <= '0;
			artifact_q  <= '0;
			pairs_q     <= '0;
			over_q      <= '0;
			s1_q        <= '0;
			s2_q        <= '0;
			d1_q        <= '0;
			d2_q        <= '0;
			prev_q      <= '0;
			prev_excl_q <= 1'b1;
			acc_s1      <= 1'b0;
			pair_s1     <= 1'b0;
			acc_s2      <= 1'b0;
			pair_s2     <= 1'b0;
		end else begin
			if (cfg_we) begin
				thr_q <= cfg_wdata;
			end

			acc_s1  <= take && !head.is_excluded;
			pair_s1 <= take && is_pair;
			acc_s2  <= acc_s1;
			pair_s2 <= pair_s1;

			if (take) begin
				total_q    <= total_q + 1'b1;
				clipped_q  <= clipped_q + CNT_W'(head.is_clipped);
				ectopic_q  <= ectopic_q + CNT_W'(head.is_ectopic);
				artifact_q <= artifact_q + CNT_W'(head.has_artifact);
				if (head.is_excluded) begin
					excluded_q <= excluded_q + 1'b1;
				end else begin
					accepted_q <= accepted_q + 1'b1;
					if (is_pair) begin
						pairs_q <= pairs_q + 1'b1;
						if (mag > thr_q) begin
							over_q <= over_q + 1'b1;
						end
					end
				end
				prev_q      <= head.rr_value_us;
				prev_excl_q <= head.is_excluded;
			end

			if (acc_s2) begin
				s1_q <= s1_q + S1_W'(v_s2);
				s2_q <= s2_sum[64] ? '1 : s2_sum[63:0];
			end
			if (pair_s2) begin
				d1_q <= d1_q + {{(D1_W-DF_W){diff_s2[DF_W-1]}}, diff_s2};
				d2_q <= d2_sum[64] ? '1 : d2_sum[63:0];
			end

			unique case (st_q)
				A_RUN: begin
					if (pop && head.last_interval) begin
						st_q <= A_DRAIN;
					end
				end
				A_DRAIN: begin
					if (!acc_s1 && !acc_s2) begin
						st_q <= A_HAND;
					end
				end
				A_HAND: begin
					if (rec_ready) begin
						st_q        <= A_RUN;
						total_q     <= '0;
						accepted_q  <= '0;
						excluded_q  <= '0;
						clipped_q   <= '0;
						ectopic_q   <= '0;
						artifact_q  <= '0;
						pairs_q     <= '0;
						over_q      <= '0;
						s1_q        <= '0;
						s2_q        <= '0;
						d1_q        <= '0;
						d2_q        <= '0;
						prev_q      <= '0;
						prev_excl_q <= 1'b1;
					end
				end
				default: st_q <= A_RUN;
			endcase
		end
	end

	assign rec_valid = (st_q == A_HAND);

	always_comb begin
		rec.total    = REC_CNT_W'(total_q);
		rec.accepted = REC_CNT_W'(accepted_q);
		rec.excluded = REC_CNT_W'(excluded_q);
		rec.clipped  = REC_CNT_W'(clipped_q);
		rec.ectopic  = REC_CNT_W'(ectopic_q);
		rec.artifact = REC_CNT_W'(artifact_q);
		rec.pairs    = REC_CNT_W'(pairs_q);
		rec.over     = REC_CNT_W'(over_q);
		rec.s1       = 64'(s1_q);
		rec.s2       = s2_q;
		rec.d1       = {{(64-D1_W){d1_q[D1_W-1]}}, d1_q};
		rec.d2       = d2_q;
	end

	`HRV_ASSERT_NEXT(a_rec_cleared, rec_valid && rec_ready, total_q == '0 && prev_excl_q, "record not cleared after hand-off")
	`HRV_ASSERT(a_drain_quiet, (st_q == A_HAND) |-> (!acc_s1 && !acc_s2), "hand-off with sums in flight")

endmodule

@@ src/hrv_tdm_calc.sv @@
`include "hrv_time_domain_metrics_top_defines.svh"

module hrv_tdm_calc import hrv_tdm_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  rec_t          rec,
	input  logic          rec_valid,
	output logic          rec_ready,
	hrv_tdm_out_if.source metric_out
);

	typedef enum logic [4:0] {
		C_IDLE, C_MEAN, C_HR_MUL, C_HR_DIV, C_QN_MUL_A, C_QN_MUL_B, C_QN_MUL_C,
		C_QN_DIV, C_SDNN, C_RMS_DIV, C_RMS_SQ, C_PNN_MUL, C_PNN_DIV, C_Q1_MUL_A,
		C_Q1_MUL_B, C_Q1_MUL_C, C_Q1_DIV, C_SD1, C_SD2, C_RATIO, C_EMIT
	} calc_state_t;

	typedef enum logic [1:0] {K_MUL, K_DIV, K_SQRT} unit_kind_t;

	localparam logic [63:0] HR_SCALE  = 64'd6000000000;
	localparam logic [63:0] PNN_SCALE = 64'd10000;

	calc_state_t      st_q;
	rec_t             rec_q;
	logic [MET_W-1:0] m_q [NUM_METRICS];
	logic [127:0]     t0_q, t1_q;
	logic [63:0]      t2_q, qnn_q, q1_q;
	logic [32:0]      sd1_q, sd2_q;
	logic [IDX_W-1:0] k_q;

	// shared iterative unit: shift-add multiply, restoring divide, digit square root
	logic             run_q;
	logic [6:0]       cnt_q;
	logic [127:0]     ma_q, mp_q;
	logic [63:0]      mb_q;
	logic [63:0]      rem_q, lo_q, den_q, quot_q;
	logic [63:0]      v_q, res_q, bit_q;

	logic             out_valid_q;
	logic [IDX_W-1:0] out_idx_q;
	logic [MET_W-1:0] out_val_q;
	logic             out_last_q;

	unit_kind_t   kind;
	logic [127:0] op_num;
	logic [63:0]  op_den, op_a, op_b, op_x;
	logic [63:0]  n64, p64, dmag, twice, sd2sq, sq_res;
	logic [64:0]  twice_sum, div_r;
	logic [63:0]  sq_t;
	logic         done;
	calc_state_t  after_hr, after_qn;

	function automatic logic [MET_W-1:0] sat32(input logic [63:0] v);
		sat32 = (v[63:MET_W] != '0) ? '1 : v[MET_W-1:0];
	endfunction

	assign n64       = 64'(rec_q.accepted);
	assign p64       = 64'(rec_q.pairs);
	assign dmag      = rec_q.d1[63] ? (64'd0 - rec_q.d1) : rec_q.d1;
	assign twice_sum = {1'b0, qnn_q} + {1'b0, qnn_q};
	assign twice     = twice_sum[64] ? '1 : twice_sum[63:0];
	assign sd2sq     = (twice >= q1_q) ? twice - q1_q : '0;
	assign sq_res    = res_q + 64'(v_q > res_q);
	assign sq_t      = res_q + bit_q;
	assign div_r     = {rem_q, lo_q[63]};
	assign done      = run_q && (cnt_q == '0);
	assign after_qn  = (rec_q.pairs == '0) ? C_EMIT : C_RMS_DIV;
	assign after_hr  = (rec_q.accepted > REC_CNT_W'(1)) ? C_QN_MUL_A : after_qn;

	// operands of the step at hand
	always_comb begin
		kind   = K_MUL;
		op_num = '0;
		op_den = '0;
		op_a   = '0;
		op_b   = '0;
		op_x   = '0;
		unique case (st_q)
			C_MEAN: begin
				kind   = K_DIV;
				op_num = 128'(rec_q.s1 + (n64 >> 1));
				op_den = n64;
			end
			C_HR_MUL: begin
				op_a = HR_SCALE;
				op_b = n64;
			end
			C_HR_DIV: begin
				kind   = K_DIV;
				op_num = t0_q + 128'(rec_q.s1 >> 1);
				op_den = rec_q.s1;
			end
			C_QN_MUL_A: begin
				op_a = n64;
				op_b = rec_q.s2;
			end
			C_QN_MUL_B: begin
				op_a = rec_q.s1;
				op_b = rec_q.s1;
			end
			C_QN_MUL_C: begin
				op_a = n64;
				op_b = n64 - 64'd1;
			end
			C_QN_DIV: begin
				kind   = K_DIV;
				op_num = (t0_q >= t1_q) ? t0_q - t1_q : '0;
				op_den = t2_q;
			end
			C_SDNN: begin
				kind = K_SQRT;
				op_x = qnn_q;
			end
			C_RMS_DIV: begin
				kind   = K_DIV;
				op_num = 128'(rec_q.d2);
				op_den = p64;
			end
			C_RMS_SQ: begin
				kind = K_SQRT;
				op_x = t2_q;
			end
			C_PNN_MUL: begin
				op_a = PNN_SCALE;
				op_b = 64'(rec_q.over);
			end
			C_PNN_DIV: begin
				kind   = K_DIV;
				op_num = t0_q + 128'(p64 >> 1);
				op_den = p64;
			end
			C_Q1_MUL_A: begin
				op_a = p64;
				op_b = rec_q.d2;
			end
			C_Q1_MUL_B: begin
				op_a = dmag;
				op_b = dmag;
			end
			C_Q1_MUL_C: begin
				op_a = p64;
				op_b = p64 - 64'd1;
			end
			C_Q1_DIV: begin
				kind   = K_DIV;
				op_num = (t0_q >= t1_q) ? t0_q - t1_q : '0;
				op_den = {t2_q[62:0], 1'b0};
			end
			C_SD1: begin
				kind = K_SQRT;
				op_x = q1_q;
			end
			C_SD2: begin
				kind = K_SQRT;
				op_x = sd2sq;
			end
			C_RATIO: begin
				kind   = K_DIV;
				op_num = 128'({sd1_q, 16'd0}) + 128'(sd2_q >> 1);
				op_den = 64'(sd2_q);
			end
			default: begin
				kind = K_MUL;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= C_IDLE;
			run_q       <= 1'b0;
			cnt_q       <= '0;
			k_q         <= '0;
			out_valid_q <= 1'b0;
			out_idx_q   <= '0;
			out_val_q   <= '0;
			out_last_q  <= 1'b0;
			rec_q       <= '0;
			t0_q        <= '0;
			t1_q        <= '0;
			t2_q        <= '0;
			qnn_q       <= '0;
			q1_q        <= '0;
			sd1_q       <= '0;
			sd2_q       <= '0;
			ma_q        <= '0;
			mp_q        <= '0;
			mb_q        <= '0;
			rem_q       <= '0;
			lo_q        <= '0;
			den_q       <= '0;
			quot_q      <= '0;
			v_q         <= '0;
			res_q       <= '0;
			bit_q       <= '0;
			for (int i = 0; i < NUM_METRICS; i++) begin
				m_q[i] <= '0;
			end
		end else begin
			// unit stepping
			if (run_q && cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				unique case (kind)
					K_MUL: begin
						if (mb_q[0]) begin
							mp_q <= mp_q + ma_q;
						end
						ma_q <= ma_q << 1;
						mb_q <= mb_q >> 1;
					end
					K_DIV: begin
						if (div_r >= {1'b0, den_q}) begin
							rem_q  <= 64'(div_r - {1'b0, den_q});
							quot_q <= {quot_q[62:0], 1'b1};
						end else begin
							rem_q  <= div_r[63:0];
							quot_q <= {quot_q[62:0], 1'b0};
						end
						lo_q <= lo_q << 1;
					end
					K_SQRT: begin
						if (v_q >= sq_t) begin
							v_q   <= v_q - sq_t;
							res_q <= (res_q >> 1) + bit_q;
						end else begin
							res_q <= res_q >> 1;
						end
						bit_q <= bit_q >> 2;
					end
					default: begin
						res_q <= res_q;
					end
				endcase
			end else if (!run_q && st_q != C_IDLE && st_q != C_EMIT) begin
				run_q <= 1'b1;
				unique case (kind)
					K_MUL: begin
						ma_q  <= 128'(op_a);
						mb_q  <= op_b;
						mp_q  <= '0;
						cnt_q <= 7'd64;
					end
					K_DIV: begin
						den_q <= op_den;
						rem_q <= op_num[127:64];
						lo_q  <= op_num[63:0];
						if (op_num[127:64] >= op_den) begin
							// quotient would not fit 64 bits
							quot_q <= '1;
							cnt_q  <= '0;
						end else begin
							quot_q <= '0;
							cnt_q  <= 7'd64;
						end
					end
					K_SQRT: begin
						v_q   <= op_x;
						res_q <= '0;
						bit_q <= 64'h4000_0000_0000_0000;
						cnt_q <= 7'd32;
					end
					default: begin
						cnt_q <= '0;
					end
				endcase
			end

			if (done) begin
				run_q <= 1'b0;
			end

			unique case (st_q)
				C_IDLE: begin
					if (rec_valid) begin
						rec_q <= rec;
						m_q[MET_TOTAL]    <= sat32(64'(rec.total));
						m_q[MET_ACCEPTED] <= sat32(64'(rec.accepted));
						m_q[MET_EXCLUDED] <= sat32(64'(rec.excluded));
						m_q[MET_CLIPPED]  <= sat32(64'(rec.clipped));
						m_q[MET_ECTOPIC]  <= sat32(64'(rec.ectopic));
						m_q[MET_ARTIFACT] <= sat32(64'(rec.artifact));
						for (int i = int'(MET_MEAN); i < NUM_METRICS; i++) begin
							m_q[i] <= '0;
						end
						qnn_q <= '0;
						q1_q  <= '0;
						sd1_q <= '0;
						sd2_q <= '0;
						st_q  <= (rec.accepted == '0) ? C_EMIT : C_MEAN;
					end
				end
				C_MEAN: if (done) begin
					m_q[MET_MEAN] <= sat32(quot_q);
					st_q <= (rec_q.s1 == '0) ? after_hr : C_HR_MUL;
				end
				C_HR_MUL: if (done) begin
					t0_q <= mp_q;
					st_q <= C_HR_DIV;
				end
				C_HR_DIV: if (done) begin
					m_q[MET_HR] <= sat32(quot_q);
					st_q <= after_hr;
				end
				C_QN_MUL_A: if (done) begin
					t0_q <= mp_q;
					st_q <= C_QN_MUL_B;
				end
				C_QN_MUL_B: if (done) begin
					t1_q <= mp_q;
					st_q <= C_QN_MUL_C;
				end
				C_QN_MUL_C: if (done) begin
					t2_q <= mp_q[63:0];
					st_q <= C_QN_DIV;
				end
				C_QN_DIV: if (done) begin
					qnn_q <= quot_q;
					st_q  <= C_SDNN;
				end
				C_SDNN: if (done) begin
					m_q[MET_SDNN] <= sat32(sq_res);
					st_q <= after_qn;
				end
				C_RMS_DIV: if (done) begin
					t2_q <= quot_q;
					st_q <= C_RMS_SQ;
				end
				C_RMS_SQ: if (done) begin
					m_q[MET_RMSSD] <= sat32(sq_res);
					st_q <= C_PNN_MUL;
				end
				C_PNN_MUL: if (done) begin
					t0_q <= mp_q;
					st_q <= C_PNN_DIV;
				end
				C_PNN_DIV: if (done) begin
					m_q[MET_PNN50] <= sat32(quot_q);
					st_q <= (rec_q.pairs > REC_CNT_W'(1)) ? C_Q1_MUL_A : C_SD1;
				end
				C_Q1_MUL_A: if (done) begin
					t0_q <= mp_q;
					st_q <= C_Q1_MUL_B;
				end
				C_Q1_MUL_B: if (done) begin
					t1_q <= mp_q;
					st_q <= C_Q1_MUL_C;
				end
				C_Q1_MUL_C: if (done) begin
					t2_q <= mp_q[63:0];
					st_q <= C_Q1_DIV;
				end
				C_Q1_DIV: if (done) begin
					q1_q <= quot_q;
					st_q <= C_SD1;
				end
				C_SD1: if (done) begin
					sd1_q <= sq_res[32:0];
					m_q[MET_SD1] <= sat32(sq_res);
					st_q <= C_SD2;
				end
				C_SD2: if (done) begin
					sd2_q <= sq_res[32:0];
					m_q[MET_SD2] <= sat32(sq_res);
					st_q <= (sq_res == '0) ? C_EMIT : C_RATIO;
				end
				C_RATIO: if (done) begin
					m_q[MET_RATIO] <= sat32(quot_q);
					st_q <= C_EMIT;
				end
				C_EMIT: begin
					// output register is only ever loaded here, so it is also cleared here
					if (!out_valid_q || metric_out.ready) begin
						if (k_q == IDX_W'(NUM_METRICS)) begin
							out_valid_q <= 1'b0;
							k_q  <= '0;
							st_q <= C_IDLE;
						end else begin
							out_valid_q <= 1'b1;
							out_idx_q   <= k_q;
							out_val_q   <= m_q[k_q];
							out_last_q  <= (k_q == MET_RATIO);
							k_q         <= k_q + 1'b1;
						end
					end
				end
				default: st_q <= C_IDLE;
			endcase
		end
	end

	assign rec_ready               = (st_q == C_IDLE);
	assign metric_out.valid        = out_valid_q;
	assign metric_out.metric_index = out_idx_q;
	assign metric_out.metric_value = out_val_q;
	assign metric_out.last_metric  = out_last_q;

	`HRV_ASSERT(a_out_in_emit, out_valid_q |-> (st_q == C_EMIT), "metric word outside output phase")
	`HRV_ASSERT(a_unit_idle, (st_q == C_IDLE || st_q == C_EMIT) |-> !run_q, "unit running while idle")

endmodule
